// ----- rtl/gaussian_polar_sampler_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the polar-method sampler
// Shared property shapes, clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef GAUSSIAN_POLAR_SAMPLER_TOP_ASSERT_SVH
`define GAUSSIAN_POLAR_SAMPLER_TOP_ASSERT_SVH

// same-cycle implication
`define GPS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define GPS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/gps_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gps_pkg
// Types, constants and datapath step functions of the polar-method sampler.
// ----------------------------------------------------------------------------
package gps_pkg;

   localparam int UNIFORM_BITS = 32;
   localparam int DEV_BITS     = 32;
   localparam int LOG_STEPS    = 26;
   localparam int ROOT_STEPS   = 32;

   localparam logic [DEV_BITS-1:0] DEV_RESET   = 32'd16777216;
   localparam logic [31:0]         TWO_LN2_Q31 = 32'd2977044472;
   localparam logic [31:0]         HALF_Q32    = 32'h8000_0000;

   typedef struct packed {
      logic [UNIFORM_BITS-1:0] uniform_first;
      logic [UNIFORM_BITS-1:0] uniform_second;
   } req_type;

   typedef struct packed {
      logic signed [31:0] normal_sample;
      logic               pair_last;
   } rsp_type;

   typedef struct packed {
      logic [33:0] rem;
      logic [31:0] root;
   } sqrt_type;

   typedef struct packed {
      logic [30:0] m;
      logic        bit_out;
   } log_type;

   typedef struct packed {
      logic [30:0] rem;
      logic [31:0] quo;
      logic [31:0] num;
   } div_type;

   // bring a uniform to 32 bits: keep the top bits or zero fill below
   function automatic logic [31:0] to_top32(input logic [UNIFORM_BITS-1:0] u);
      logic [63:0] w;
      w = 64'(u);
      if (UNIFORM_BITS >= 32) begin
         return 32'(w >> (UNIFORM_BITS - 32));
      end else begin
         return 32'(w << (32 - UNIFORM_BITS));
      end
   endfunction

   // magnitude of (a - 1/2) in Q.32, that is of (2a - 1) in Q.31
   function automatic logic [31:0] centre_mag(input logic [31:0] a);
      if (a[31]) begin
         return {1'b0, a[30:0]};
      end else begin
         return HALF_Q32 - a;
      end
   endfunction

   // position of the leading one
   function automatic logic [5:0] lead_pos(input logic [61:0] r);
      logic [5:0] pos;
      pos = '0;
      for (int i = 0; i < 62; i++) begin
         if (r[i]) begin
            pos = 6'(i);
         end
      end
      return pos;
   endfunction

   // one bit of a restoring square root: take two radicand bits
   function automatic sqrt_type sqrt_step(input sqrt_type cur, input logic [1:0] pair);
      logic [35:0] acc;
      logic [35:0] trial;
      sqrt_type    nxt;
      acc   = {cur.rem, pair};
      trial = {2'b00, cur.root, 2'b01};
      if (acc >= trial) begin
         nxt.rem  = 34'(acc - trial);
         nxt.root = {cur.root[30:0], 1'b1};
      end else begin
         nxt.rem  = acc[33:0];
         nxt.root = {cur.root[30:0], 1'b0};
      end
      return nxt;
   endfunction

   // one fraction bit of log2: square the Q1.30 mantissa, renormalise
   function automatic log_type log_step(input logic [30:0] m);
      logic [61:0] sq;
      logic [31:0] s;
      log_type     nxt;
      sq          = 62'(m) * 62'(m);
      s           = sq[61:30];
      nxt.bit_out = s[31];
      nxt.m       = s[31] ? s[31:1] : s[30:0];
      return nxt;
   endfunction

   // one quotient bit of a restoring division
   function automatic div_type div_step(input div_type cur, input logic [30:0] den);
      logic [31:0] acc;
      div_type     nxt;
      acc     = {cur.rem, cur.num[31]};
      nxt.num = {cur.num[30:0], 1'b0};
      if (acc >= {1'b0, den}) begin
         nxt.rem = 31'(acc - {1'b0, den});
         nxt.quo = {cur.quo[30:0], 1'b1};
      end else begin
         nxt.rem = acc[30:0];
         nxt.quo = {cur.quo[30:0], 1'b0};
      end
      return nxt;
   endfunction

   // apply the sign and saturate a magnitude to signed 32 bits
   function automatic logic signed [31:0] saturate(input logic [36:0] m, input logic neg);
      logic [36:0] lim;
      logic [36:0] mag;
      lim = neg ? 37'(HALF_Q32) : 37'(HALF_Q32) - 37'd1;
      mag = (m > lim) ? lim : m;
      return neg ? 32'(37'd0 - mag) : mag[31:0];
   endfunction

endpackage
`default_nettype wire

// ----- rtl/gaussian_polar_sampler_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gaussian_polar_sampler_top
// Marsaglia polar method: maps a pair of uniforms to two scaled normal samples.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  req_     in         req_valid/req_stall  gps_pkg::req_type (two uniforms)
//  rsp_     out        rsp_valid/rsp_stall  gps_pkg::rsp_type (sample, last)
//  csr_     in         csr_wr_en            deviation scale, Q8.24
//
//  A transaction may enter every cycle while req_stall is low; the path is
//  74 register stages deep and the result register adds one. The v2 sample
//  of a pair shows first and its partner, marked last, follows it.
//  Each kept pair leaves as two result transactions from the single result
//  register, which bounds the output side.
//  Rejected pairs turn into bubbles after the sum-of-squares stage.
//  Reset is synchronous, active high; it clears the valid bits and returns
//  the scale to 1.0.
//  All stages advance together unless the last stage holds a pair that the
//  result register cannot take; then every stage holds, bubbles included.
// ----------------------------------------------------------------------------
module gaussian_polar_sampler_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  gps_pkg::req_type            req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output gps_pkg::rsp_type            rsp_data,
   input  logic                        csr_wr_en,
   input  logic [gps_pkg::DEV_BITS-1:0] csr_wr_data
);

   localparam int NumSteps = gps_pkg::ROOT_STEPS;
   localparam int LogSteps = gps_pkg::LOG_STEPS;

   // front end: centring, squares, sum, leading one
   typedef struct packed {
      logic        n1;
      logic        n2;
      logic [31:0] m1;
      logic [31:0] m2;
   } a0_type;

   typedef struct packed {
      logic        n1;
      logic        n2;
      logic [31:0] m1;
      logic [31:0] m2;
      logic [62:0] sq1;
      logic [62:0] sq2;
   } a1_type;

   typedef struct packed {
      logic        n1;
      logic        n2;
      logic [30:0] m1;
      logic [30:0] m2;
      logic [61:0] r;
   } a2_type;

   typedef struct packed {
      logic        n1;
      logic        n2;
      logic [30:0] m1;
      logic [30:0] m2;
      logic [61:0] r;
      logic [5:0]  p;
   } a3_type;

   // log2 and sqrt(rsq) stages
   typedef struct packed {
      logic              n1;
      logic              n2;
      logic [30:0]       w1;
      logic [30:0]       w2;
      logic [5:0]        ip;
      logic [30:0]       lm;
      logic [25:0]       frac;
      logic [63:0]       qx;
      gps_pkg::sqrt_type qs;
   } b_type;

   typedef struct packed {
      logic        n1;
      logic        n2;
      logic [30:0] w1;
      logic [30:0] w2;
      logic [30:0] q;
      logic [62:0] t;
   } c_type;

   // sqrt(-2 ln rsq) and the two divisions
   typedef struct packed {
      logic              n1;
      logic              n2;
      logic [30:0]       q;
      logic [63:0]       hx;
      gps_pkg::sqrt_type hs;
      gps_pkg::div_type  d1;
      gps_pkg::div_type  d2;
   } d_type;

   typedef struct packed {
      logic        n1;
      logic        n2;
      logic [63:0] p1;
      logic [63:0] p2;
   } e_type;

   typedef struct packed {
      logic        n1;
      logic        n2;
      logic [64:0] mp1;
      logic [64:0] mp2;
   } f_type;

   typedef struct packed {
      logic signed [31:0] s1;
      logic signed [31:0] s2;
   } g_type;

   logic [gps_pkg::DEV_BITS-1:0] dev_ff;

   a0_type a0_ff, a0_in;
   a1_type a1_ff, a1_in;
   a2_type a2_ff, a2_in;
   a3_type a3_ff, a3_in;
   b_type  b_ff [0:NumSteps];
   b_type  b0_in;
   b_type  b_in [1:NumSteps];
   c_type  c_ff, c_in;
   d_type  d_ff [0:NumSteps];
   d_type  d0_in;
   d_type  d_in [1:NumSteps];
   e_type  e_ff, e_in;
   f_type  f_ff, f_in;
   g_type  g_ff, g_in;

   logic [3:0]        a_vld_ff;
   logic              a2_ok;
   logic [NumSteps:0] b_vld_ff;
   logic              c_vld_ff;
   logic [NumSteps:0] d_vld_ff;
   logic              e_vld_ff;
   logic              f_vld_ff;
   logic              g_vld_ff;

   logic        pair_vld_ff;
   logic        phase_ff;
   g_type       pair_ff;
   logic        pair_free;
   logic        pair_load;
   logic        en;

   logic [31:0] u1;
   logic [31:0] u2;
   logic [63:0] r_sum;
   logic [61:0] norm;
   logic [4:0]  esh;
   logic [31:0] lg;
   logic [63:0] lg_prod;
   logic [31:0] h;
   logic [31:0] c1;
   logic [31:0] c2;
   logic [32:0] z1;
   logic [32:0] z2;
   gps_pkg::log_type lstep;

   // advance everything unless the last stage is full and blocked
   assign pair_free = !pair_vld_ff || (phase_ff && !rsp_stall);
   assign pair_load = g_vld_ff && pair_free;
   assign en        = !g_vld_ff || pair_free;
   assign req_stall = !en;

   // centre the uniforms and keep sign and magnitude
   always_comb begin
      u1       = gps_pkg::to_top32(req_data.uniform_first);
      u2       = gps_pkg::to_top32(req_data.uniform_second);
      a0_in.n1 = !u1[31];
      a0_in.n2 = !u2[31];
      a0_in.m1 = gps_pkg::centre_mag(u1);
      a0_in.m2 = gps_pkg::centre_mag(u2);
   end

   always_comb begin
      a1_in.n1  = a0_ff.n1;
      a1_in.n2  = a0_ff.n2;
      a1_in.m1  = a0_ff.m1;
      a1_in.m2  = a0_ff.m2;
      a1_in.sq1 = 63'(64'(a0_ff.m1) * 64'(a0_ff.m1));
      a1_in.sq2 = 63'(64'(a0_ff.m2) * 64'(a0_ff.m2));
   end

   // drop pairs outside the open unit disc, and the origin
   always_comb begin
      r_sum    = 64'(a1_ff.sq1) + 64'(a1_ff.sq2);
      a2_ok    = (r_sum != 64'd0) && (r_sum[63:62] == 2'b00);
      a2_in.n1 = a1_ff.n1;
      a2_in.n2 = a1_ff.n2;
      a2_in.m1 = a1_ff.m1[30:0];
      a2_in.m2 = a1_ff.m2[30:0];
      a2_in.r  = r_sum[61:0];
   end

   always_comb begin
      a3_in.n1 = a2_ff.n1;
      a3_in.n2 = a2_ff.n2;
      a3_in.m1 = a2_ff.m1;
      a3_in.m2 = a2_ff.m2;
      a3_in.r  = a2_ff.r;
      a3_in.p  = gps_pkg::lead_pos(a2_ff.r);
   end

   // normalise: log mantissa in Q1.30, rsq scaled by 4^e into [1/4, 1)
   always_comb begin
      norm  = a3_ff.r << (6'd61 - a3_ff.p);
      esh   = (a3_ff.p >= 6'd60) ? 5'd0 : 5'((6'd61 - a3_ff.p) >> 1);
      b0_in.n1   = a3_ff.n1;
      b0_in.n2   = a3_ff.n2;
      b0_in.w1   = a3_ff.m1 << esh;
      b0_in.w2   = a3_ff.m2 << esh;
      b0_in.ip   = 6'd62 - a3_ff.p;
      b0_in.lm   = norm[61:31];
      b0_in.frac = '0;
      b0_in.qx   = {2'b00, a3_ff.r} << {esh, 1'b0};
      b0_in.qs   = '0;
   end

   // one root bit per stage, and one log bit in each of the first LogSteps stages
   always_comb begin
      lstep = '0;
      for (int k = 0; k < NumSteps; k++) begin
         lstep        = '0;
         b_in[k+1]    = b_ff[k];
         b_in[k+1].qx = {b_ff[k].qx[61:0], 2'b00};
         b_in[k+1].qs = gps_pkg::sqrt_step(b_ff[k].qs, b_ff[k].qx[63:62]);
         if (k < LogSteps) begin
            lstep          = gps_pkg::log_step(b_ff[k].lm);
            b_in[k+1].lm   = lstep.m;
            b_in[k+1].frac = {b_ff[k].frac[24:0], lstep.bit_out};
         end
      end
   end

   // -2 ln(rsq) = -log2(rsq) * 2 ln 2
   always_comb begin
      lg      = {b_ff[NumSteps].ip, 26'd0} - {6'd0, b_ff[NumSteps].frac};
      lg_prod = 64'(lg) * 64'(gps_pkg::TWO_LN2_Q31);
      c_in.n1 = b_ff[NumSteps].n1;
      c_in.n2 = b_ff[NumSteps].n2;
      c_in.w1 = b_ff[NumSteps].w1;
      c_in.w2 = b_ff[NumSteps].w2;
      c_in.q  = b_ff[NumSteps].qs.root[30:0];
      c_in.t  = lg_prod[63:1];
   end

   always_comb begin
      d0_in.n1     = c_ff.n1;
      d0_in.n2     = c_ff.n2;
      d0_in.q      = c_ff.q;
      d0_in.hx     = {1'b0, c_ff.t};
      d0_in.hs     = '0;
      d0_in.d1.rem = 31'(c_ff.w1 >> 1);
      d0_in.d1.quo = '0;
      d0_in.d1.num = {c_ff.w1[0], 31'd0};
      d0_in.d2.rem = 31'(c_ff.w2 >> 1);
      d0_in.d2.quo = '0;
      d0_in.d2.num = {c_ff.w2[0], 31'd0};
   end

   // one root bit of h and one quotient bit per lane per stage
   always_comb begin
      for (int k = 0; k < NumSteps; k++) begin
         d_in[k+1]    = d_ff[k];
         d_in[k+1].hx = {d_ff[k].hx[61:0], 2'b00};
         d_in[k+1].hs = gps_pkg::sqrt_step(d_ff[k].hs, d_ff[k].hx[63:62]);
         d_in[k+1].d1 = gps_pkg::div_step(d_ff[k].d1, d_ff[k].q);
         d_in[k+1].d2 = gps_pkg::div_step(d_ff[k].d2, d_ff[k].q);
      end
   end

   // cap the ratio at one, multiply by h
   always_comb begin
      h       = d_ff[NumSteps].hs.root;
      c1      = (d_ff[NumSteps].d1.quo > gps_pkg::HALF_Q32) ? gps_pkg::HALF_Q32
                                                             : d_ff[NumSteps].d1.quo;
      c2      = (d_ff[NumSteps].d2.quo > gps_pkg::HALF_Q32) ? gps_pkg::HALF_Q32
                                                             : d_ff[NumSteps].d2.quo;
      e_in.n1 = d_ff[NumSteps].n1;
      e_in.n2 = d_ff[NumSteps].n2;
      e_in.p1 = 64'(c1) * 64'(h);
      e_in.p2 = 64'(c2) * 64'(h);
   end

   // apply the deviation scale
   always_comb begin
      z1       = e_ff.p1[63:31];
      z2       = e_ff.p2[63:31];
      f_in.n1  = e_ff.n1;
      f_in.n2  = e_ff.n2;
      f_in.mp1 = 65'(z1) * 65'(dev_ff);
      f_in.mp2 = 65'(z2) * 65'(dev_ff);
   end

   always_comb begin
      g_in.s1 = gps_pkg::saturate(f_ff.mp1[64:28], f_ff.n1);
      g_in.s2 = gps_pkg::saturate(f_ff.mp2[64:28], f_ff.n2);
   end

   // valid bits: the disc test judges the pair leaving the squares stage
   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= '0;
         b_vld_ff <= '0;
         c_vld_ff <= 1'b0;
         d_vld_ff <= '0;
         e_vld_ff <= 1'b0;
         f_vld_ff <= 1'b0;
         g_vld_ff <= 1'b0;
      end else if (en) begin
         a_vld_ff <= {a_vld_ff[2], a_vld_ff[1] & a2_ok, a_vld_ff[0], req_valid};
         b_vld_ff <= {b_vld_ff[NumSteps-1:0], a_vld_ff[3]};
         c_vld_ff <= b_vld_ff[NumSteps];
         d_vld_ff <= {d_vld_ff[NumSteps-1:0], c_vld_ff};
         e_vld_ff <= d_vld_ff[NumSteps];
         f_vld_ff <= e_vld_ff;
         g_vld_ff <= f_vld_ff;
      end
   end

   // datapath registers: no reset
   always_ff @(posedge clock) begin
      if (en) begin
         a0_ff   <= a0_in;
         a1_ff   <= a1_in;
         a2_ff   <= a2_in;
         a3_ff   <= a3_in;
         b_ff[0] <= b0_in;
         for (int k = 1; k <= NumSteps; k++) begin
            b_ff[k] <= b_in[k];
         end
         c_ff    <= c_in;
         d_ff[0] <= d0_in;
         for (int k = 1; k <= NumSteps; k++) begin
            d_ff[k] <= d_in[k];
         end
         e_ff    <= e_in;
         f_ff    <= f_in;
         g_ff    <= g_in;
      end
   end

   // result register: v2 sample first, then v1 sample marked last
   always_ff @(posedge clock) begin
      if (reset) begin
         pair_vld_ff <= 1'b0;
         phase_ff    <= 1'b0;
      end else if (pair_load) begin
         pair_vld_ff <= 1'b1;
         phase_ff    <= 1'b0;
      end else if (pair_vld_ff && !rsp_stall) begin
         pair_vld_ff <= !phase_ff;
         phase_ff    <= !phase_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pair_load) begin
         pair_ff <= g_ff;
      end
   end

   assign rsp_valid              = pair_vld_ff;
   assign rsp_data.normal_sample = phase_ff ? pair_ff.s1 : pair_ff.s2;
   assign rsp_data.pair_last     = phase_ff;

   // deviation scale register
   always_ff @(posedge clock) begin
      if (reset) begin
         dev_ff <= gps_pkg::DEV_RESET;
      end else if (csr_wr_en) begin
         dev_ff <= csr_wr_data;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/gps_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gps_checker
// Port-level checks on the sampler, bound to the top level.
// ----------------------------------------------------------------------------
`include "gaussian_polar_sampler_top_assert.svh"

module gps_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_stall,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_stall,
   input wire gps_pkg::rsp_type             rsp_data
);

   // a first sample taken is always followed by its partner
   `GPS_ASSERT_NEXT(a_pair_follows, rsp_valid && !rsp_stall && !rsp_data.pair_last,
                    rsp_valid && rsp_data.pair_last, "first sample not followed by last")

   // input holds off only while a result waits
   `GPS_ASSERT_NOW(a_stall_cause, req_stall, rsp_valid, "input stalled with no result waiting")

   // nothing leaves straight out of reset
   `GPS_ASSERT_NOW(a_reset_quiet, $past(reset), !rsp_valid, "result shown after reset")

   // a stalled result holds
   `GPS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
                    rsp_valid && $stable(rsp_data), "stalled result changed")

endmodule

bind gaussian_polar_sampler_top gps_checker u_gps_checker (.*);
`default_nettype wire
